// File: hdl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: operation and status
// codes, the input and result words, and the controller/datapath command set.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 6;
    localparam int STAT_W       = 2;
    localparam int CAPACITY_DEF = 32;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RETRIEVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOCATE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         count;
        logic                     is_empty;
        logic                     is_full;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic              wr_en;
        logic              wr_val;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              cnt_clr;
        logic              res_load;
        logic              res_read;
        logic [STAT_W-1:0] res_status;
        logic [POS_W-1:0]  res_found;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic              match;
    } t_dp_stat;

endpackage

// File: hdl/pal_datapath.sv
// ----------------------------------------------------------------------------
// pal_datapath
// Entry memory with registered read, entry count, latched operation word and
// the result register with its strobe.
// ----------------------------------------------------------------------------
module pal_datapath #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pal_pkg::t_in     i_item,
    input  pal_pkg::t_dp_cmd i_cmd,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    output pal_pkg::t_dp_stat o_stat,
    output logic [CW-1:0]    o_count,
    output logic             o_done,
    output pal_pkg::t_out    o_result
);
    import pal_pkg::*;

    localparam int OW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;
    t_in               r_item;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [OW-1:0]     n_count_w;
    logic              r_done;
    t_out              r_res;

    // latch the operation word on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_cmd.wr_val ? r_item.value : r_rdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // next entry count
    always_comb begin
        priority if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign n_count_w = OW'(n_count);

    // hold count, build the result word and pulse the strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.res_load;
        end
        if (i_cmd.res_load) begin
            r_res.status         <= i_cmd.res_status;
            r_res.read_value     <= i_cmd.res_read ? r_rdata : '0;
            r_res.found_position <= i_cmd.res_found;
            r_res.count          <= n_count_w[POS_W-1:0];
            r_res.is_empty       <= (n_count == '0);
            r_res.is_full        <= (n_count == CW'(CAPACITY));
        end
    end

    assign o_stat.kind  = r_item.kind;
    assign o_stat.pos   = r_item.position;
    assign o_stat.match = (r_rdata == r_item.value);
    assign o_count      = r_count;
    assign o_done       = r_done;
    assign o_result     = r_res;

endmodule

// File: hdl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Operation sequencer: checks the position, then walks the entry memory one
// entry per cycle to shift up, shift down or search, and issues the result.
// ----------------------------------------------------------------------------
module pal_ctrl #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pal_pkg::t_dp_stat i_stat,
    input  logic [CW-1:0]     i_count,
    output logic              o_busy,
    output pal_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_rd_addr,
    output logic [AW-1:0]     o_wr_addr
);
    import pal_pkg::*;

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_RD_WAIT,
        S_SCAN
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;

    logic [XW-1:0] w_pos, w_cnt, w_ptr;
    logic [XW-1:0] w_pos_m1, w_cnt_m1, w_cnt_p1, w_ptr_p1, w_ptr_m1;
    logic          pos_zero, ins_bad, idx_bad, is_full_now;

    // widened operands for range checks and address math
    always_comb begin
        w_pos       = XW'(i_stat.pos);
        w_cnt       = XW'(i_count);
        w_ptr       = XW'(r_ptr);
        w_pos_m1    = w_pos - XW'(1);
        w_cnt_m1    = w_cnt - XW'(1);
        w_cnt_p1    = w_cnt + XW'(1);
        w_ptr_p1    = w_ptr + XW'(1);
        w_ptr_m1    = w_ptr - XW'(1);
        pos_zero    = (w_pos == '0);
        ins_bad     = pos_zero || (w_pos > w_cnt_p1);
        idx_bad     = pos_zero || (w_pos > w_cnt);
        is_full_now = (w_cnt >= XW'(CAPACITY));
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        o_cmd     = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    KIND_INSERT: begin
                        priority if (is_full_now) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                            n_state          = S_IDLE;
                        end else if (ins_bad) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else if (w_pos == w_cnt_p1) begin
                            // append: nothing to move
                            n_state = S_INS_WR;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_rd_addr   = w_cnt_m1[AW-1:0];
                            n_ptr       = w_cnt_m1[AW-1:0];
                            n_state     = S_SHIFT_UP;
                        end
                    end
                    KIND_DELETE: begin
                        priority if (idx_bad) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else if (w_pos == w_cnt) begin
                            // drop the last entry
                            o_cmd.cnt_dec  = 1'b1;
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_rd_addr   = w_pos[AW-1:0];
                            n_ptr       = w_pos[AW-1:0];
                            n_state     = S_SHIFT_DN;
                        end
                    end
                    KIND_RETRIEVE: begin
                        if (idx_bad) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_rd_addr   = w_pos_m1[AW-1:0];
                            n_state     = S_RD_WAIT;
                        end
                    end
                    KIND_LOCATE: begin
                        if (w_cnt == '0) begin
                            o_cmd.res_load  = 1'b1;
                            o_cmd.res_found = w_cnt_p1[POS_W-1:0];
                            n_state         = S_IDLE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_rd_addr   = '0;
                            n_ptr       = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    KIND_CLEAR: begin
                        o_cmd.cnt_clr  = 1'b1;
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // move the word just read one place up
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = w_ptr_p1[AW-1:0];
                if (w_ptr == w_pos_m1) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = w_ptr_m1[AW-1:0];
                    n_ptr       = w_ptr_m1[AW-1:0];
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_val   = 1'b1;
                o_wr_addr      = w_pos_m1[AW-1:0];
                o_cmd.cnt_inc  = 1'b1;
                o_cmd.res_load = 1'b1;
                n_state        = S_IDLE;
            end
            S_SHIFT_DN: begin
                // move the word just read one place down
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = w_ptr_m1[AW-1:0];
                if (w_ptr == w_cnt_m1) begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = w_ptr_p1[AW-1:0];
                    n_ptr       = w_ptr_p1[AW-1:0];
                end
            end
            S_RD_WAIT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_read = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                priority if (i_stat.match) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = w_ptr_p1[POS_W-1:0];
                    n_state         = S_IDLE;
                end else if (w_ptr == w_cnt_m1) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = w_cnt_p1[POS_W-1:0];
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = w_ptr_p1[AW-1:0];
                    n_ptr       = w_ptr_p1[AW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hdl/positional_array_list.sv
// Clear, full or range refusals, delete of the last entry, locate in an empty
// list and unused kinds are answered from the decode state; retrieve and
// append pass through one more state (read wait or insert write); other
// inserts, deletes and locates then move or compare one entry per cycle.
// Throughput: one word per operation; a new word may be accepted in the cycle
// its predecessor's result shows. Reset empties the list, not the entries.
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed words with 1-based positions: insert,
// delete, retrieve, locate and clear, each answered by one result word.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pal_pkg::t_in  i_item,
    output logic          o_done,
    output pal_pkg::t_out o_result
);
    import pal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [CW-1:0] dp_count;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // sequencer
    pal_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_stat    (dp_stat),
        .i_count   (dp_count),
        .o_busy    (busy),
        .o_cmd     (dp_cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    // storage and result
    pal_datapath #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (dp_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_stat    (dp_stat),
        .o_count   (dp_count),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    // a result word always follows the command that issues it
    a_res_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |=> o_done)
        else $error("result load not followed by strobe");

    // the strobe only closes an operation that was in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding operation");

    // memory writes happen only inside an operation
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.wr_en |-> busy)
        else $error("entry write while idle");

    // an accepted word keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start an operation");

endmodule
